@@ rtl/i2p_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_pkg
// Types, codes and operator tables shared by the infix-to-postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_final;
  } item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] status;
    logic       run_last;
  } result_t;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNMATCHED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_UNKNOWN   = 2'd3;

  // waiting relational
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_GT   = 2'd1;
  localparam logic [1:0] PEND_LT   = 2'd2;

  localparam logic [5:0] MAX_RESULTS = 6'd40;

  // stack operator codes
  localparam logic [3:0] OP_PAREN = 4'd0;
  localparam logic [3:0] OP_OR    = 4'd1;
  localparam logic [3:0] OP_AND   = 4'd2;
  localparam logic [3:0] OP_EQ    = 4'd3;
  localparam logic [3:0] OP_NE    = 4'd4;
  localparam logic [3:0] OP_GE    = 4'd5;
  localparam logic [3:0] OP_LE    = 4'd6;
  localparam logic [3:0] OP_GT    = 4'd7;
  localparam logic [3:0] OP_LT    = 4'd8;
  localparam logic [3:0] OP_ADD   = 4'd9;
  localparam logic [3:0] OP_SUB   = 4'd10;
  localparam logic [3:0] OP_MUL   = 4'd11;
  localparam logic [3:0] OP_DIV   = 4'd12;
  localparam logic [3:0] OP_POW   = 4'd13;

  // characters
  localparam logic [7:0] CH_0      = "0";
  localparam logic [7:0] CH_9      = "9";
  localparam logic [7:0] CH_UA     = "A";
  localparam logic [7:0] CH_UZ     = "Z";
  localparam logic [7:0] CH_LA     = "a";
  localparam logic [7:0] CH_LZ     = "z";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_BAR    = "|";
  localparam logic [7:0] CH_AMP    = "&";
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_BANG   = "!";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_CARET  = "^";
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    K_ALNUM,
    K_OPEN,
    K_CLOSE,
    K_BIN,
    K_REL,
    K_BAD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] code;
    logic [2:0] prio;
    logic       two;
    logic [1:0] pend;
  } dec_t;

  typedef enum logic [1:0] {
    M_PRIO,
    M_PAREN,
    M_ALL
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_EQ_PUSH,
    S_PEND_PUSH,
    S_PROC,
    S_RD,
    S_CHK,
    S_POP2,
    S_LEND,
    S_OP_PUSH,
    S_FIN,
    S_FIN_PUSH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic       push;
    logic       pop;
    logic       rd;
    logic       set_pend;
    logic       clr_pend;
    logic       set_skip;
    logic       clr_skip;
    logic       flush;
    logic [7:0] ch;
    logic [1:0] st;
    logic [3:0] code;
    logic [1:0] pend_val;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] c;
    logic       fin;
    logic [1:0] pend;
    logic       skip;
    logic       empty;
    logic       full;
    logic [3:0] top;
    logic       emit_ok;
    logic       hold_valid;
    logic       out_free;
  } dp_sts_t;

  function automatic logic [2:0] op_prio(input logic [3:0] code);
    logic [2:0] p;
    case (code)
      OP_OR:                                      p = 3'd1;
      OP_AND:                                     p = 3'd2;
      OP_EQ, OP_NE, OP_GE, OP_LE, OP_GT, OP_LT:   p = 3'd3;
      OP_ADD, OP_SUB:                             p = 3'd4;
      OP_MUL, OP_DIV:                             p = 3'd5;
      OP_POW:                                     p = 3'd6;
      default:                                    p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] op_first(input logic [3:0] code);
    logic [7:0] ch;
    case (code)
      OP_PAREN:        ch = CH_LPAREN;
      OP_OR:           ch = CH_BAR;
      OP_AND:          ch = CH_AMP;
      OP_EQ:           ch = CH_EQ;
      OP_NE:           ch = CH_BANG;
      OP_GE, OP_GT:    ch = CH_GT;
      OP_LE, OP_LT:    ch = CH_LT;
      OP_ADD:          ch = CH_PLUS;
      OP_SUB:          ch = CH_MINUS;
      OP_MUL:          ch = CH_STAR;
      OP_DIV:          ch = CH_SLASH;
      OP_POW:          ch = CH_CARET;
      default:         ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] op_second(input logic [3:0] code);
    logic [7:0] ch;
    case (code)
      OP_OR:                         ch = CH_BAR;
      OP_AND:                        ch = CH_AMP;
      OP_EQ, OP_NE, OP_GE, OP_LE:    ch = CH_EQ;
      default:                       ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic dec_t op_decode(input logic [7:0] c);
    dec_t d;
    d.kind = K_BAD;
    d.code = OP_PAREN;
    d.prio = 3'd0;
    d.two  = 1'b0;
    d.pend = PEND_NONE;
    if ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
        (c >= CH_LA && c <= CH_LZ)) begin
      d.kind = K_ALNUM;
    end else begin
      case (c)
        CH_LPAREN: d.kind = K_OPEN;
        CH_RPAREN: d.kind = K_CLOSE;
        CH_BAR:    begin d.kind = K_BIN; d.code = OP_OR;  d.two = 1'b1; end
        CH_AMP:    begin d.kind = K_BIN; d.code = OP_AND; d.two = 1'b1; end
        CH_EQ:     begin d.kind = K_BIN; d.code = OP_EQ;  d.two = 1'b1; end
        CH_BANG:   begin d.kind = K_BIN; d.code = OP_NE;  d.two = 1'b1; end
        CH_GT:     begin d.kind = K_REL; d.code = OP_GT;  d.pend = PEND_GT; end
        CH_LT:     begin d.kind = K_REL; d.code = OP_LT;  d.pend = PEND_LT; end
        CH_PLUS:   begin d.kind = K_BIN; d.code = OP_ADD; end
        CH_MINUS:  begin d.kind = K_BIN; d.code = OP_SUB; end
        CH_STAR:   begin d.kind = K_BIN; d.code = OP_MUL; end
        CH_SLASH:  begin d.kind = K_BIN; d.code = OP_DIV; end
        CH_CARET:  begin d.kind = K_BIN; d.code = OP_POW; end
        default:   d.kind = K_BAD;
      endcase
      d.prio = op_prio(d.code);
    end
    return d;
  endfunction

endpackage
`default_nettype wire

@@ rtl/infix_to_postfix_converter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Streaming shunting-yard converter: infix ASCII characters in, postfix
// characters out, with error results for bad input.
// ----------------------------------------------------------------------------
// One infix character is taken per input transaction, and the block works on
// it alone until all its results are handed on. Each stacked operator popped
// costs a stack memory read and a compare, plus a further emit for the second
// character of a two-character operator, so a long pop run or the flush after
// is_final scales with the stack depth reached. Results are marked run_last on
// the last one of each transaction; one result is held back internally until
// it is known whether another follows. A stall on result_ready holds the
// sequencer only when a new result must move out. The stack memory needs no
// clearing after reset.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  i2p_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output i2p_pkg::result_t result
);
  import i2p_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  i2p_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  i2p_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

@@ rtl/i2p_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_dp
// Datapath: operator stack memory, stack count, relational wait and skip
// flags, one-deep result hold (to mark the last result) and output register.
// ----------------------------------------------------------------------------
module i2p_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  i2p_pkg::item_t    item,
  input  i2p_pkg::dp_cmd_t  cmd,
  output i2p_pkg::dp_sts_t  sts,
  output logic              result_valid,
  input  logic              result_ready,
  output i2p_pkg::result_t  result
);
  import i2p_pkg::*;

  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  logic [3:0]    mem [STACK_DEPTH];
  logic [CW-1:0] count;
  logic [CW-1:0] count_m1;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic [3:0]    top;
  logic [7:0]    c;
  logic          fin;
  logic [1:0]    pend;
  logic          skip;
  logic [5:0]    res_cnt;
  logic          hold_valid;
  logic [7:0]    hold_char;
  logic [1:0]    hold_st;
  logic          full;
  logic          cap;
  logic          out_free;
  logic          emit_ok;
  logic          emit_go;
  logic          flush_go;
  logic          out_load;

  assign count_m1 = count - CW'(1);
  assign rd_addr  = count_m1[IW-1:0];
  assign wr_addr  = count[IW-1:0];
  assign full     = (count == DEPTH_C);
  assign cap      = (res_cnt == MAX_RESULTS);
  assign out_free = !result_valid || result_ready;
  // results past the limit are dropped, so the emit completes at once
  assign emit_ok  = cap || !hold_valid || out_free;
  assign emit_go  = cmd.emit && emit_ok && !cap;
  assign flush_go = cmd.flush && hold_valid && out_free;
  assign out_load = (emit_go && hold_valid) || flush_go;

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[wr_addr] <= cmd.code;
    end
    if (cmd.rd) begin
      top <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= PEND_NONE;
      skip  <= 1'b0;
    end else begin
      if (cmd.push && !full) begin
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        count <= count_m1;
      end
      if (cmd.clr_pend) begin
        pend <= PEND_NONE;
      end else if (cmd.set_pend) begin
        pend <= cmd.pend_val;
      end
      if (cmd.clr_skip) begin
        skip <= 1'b0;
      end else if (cmd.set_skip) begin
        skip <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c   <= item.in_char;
      fin <= item.is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      res_cnt    <= '0;
    end else if (cmd.load) begin
      hold_valid <= 1'b0;
      res_cnt    <= '0;
    end else if (emit_go) begin
      hold_valid <= 1'b1;
      res_cnt    <= res_cnt + 6'd1;
    end else if (flush_go) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      hold_char <= cmd.ch;
      hold_st   <= cmd.st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.out_char <= hold_char;
      result.status   <= hold_st;
      result.run_last <= flush_go;
    end
  end

  always_comb begin
    sts.c          = c;
    sts.fin        = fin;
    sts.pend       = pend;
    sts.skip       = skip;
    sts.empty      = (count == '0);
    sts.full       = full;
    sts.top        = top;
    sts.emit_ok    = emit_ok;
    sts.hold_valid = hold_valid;
    sts.out_free   = out_free;
  end

endmodule
`default_nettype wire

@@ rtl/i2p_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_ctrl
// Controller: sequences one character through wait/skip handling, operator
// pops, push and final flush, driving the datapath by command.
// ----------------------------------------------------------------------------
module i2p_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  i2p_pkg::dp_sts_t  sts,
  output i2p_pkg::dp_cmd_t  cmd
);
  import i2p_pkg::*;

  state_t state, state_next;
  mode_t  mode, mode_next;
  dec_t   dec;
  logic   stop;
  logic   push_done;

  assign dec       = op_decode(sts.c);
  assign push_done = !sts.full || sts.emit_ok;

  always_comb begin
    case (mode)
      M_PRIO:  stop = (sts.top == OP_PAREN) || (op_prio(sts.top) < dec.prio);
      M_PAREN: stop = (sts.top == OP_PAREN);
      default: stop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= M_PRIO;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  always_comb begin
    state_next = state;
    mode_next  = mode;
    item_ready = 1'b0;
    cmd        = '0;
    cmd.st     = ST_OK;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        if (sts.skip) begin
          cmd.clr_skip = 1'b1;
          state_next   = S_FIN;
        end else if (sts.pend != PEND_NONE && sts.c == CH_EQ) begin
          state_next = S_EQ_PUSH;
        end else if (sts.pend != PEND_NONE) begin
          state_next = S_PEND_PUSH;
        end else begin
          state_next = S_PROC;
        end
      end
      S_EQ_PUSH: begin
        cmd.push = 1'b1;
        cmd.emit = sts.full;
        cmd.st   = ST_OVERFLOW;
        cmd.code = (sts.pend == PEND_GT) ? OP_GE : OP_LE;
        cmd.ch   = (sts.pend == PEND_GT) ? CH_GT : CH_LT;
        if (push_done) begin
          cmd.clr_pend = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_PEND_PUSH: begin
        cmd.push = 1'b1;
        cmd.emit = sts.full;
        cmd.st   = ST_OVERFLOW;
        cmd.code = (sts.pend == PEND_GT) ? OP_GT : OP_LT;
        cmd.ch   = (sts.pend == PEND_GT) ? CH_GT : CH_LT;
        if (push_done) begin
          cmd.clr_pend = 1'b1;
          state_next   = S_PROC;
        end
      end
      S_PROC: begin
        cmd.ch = sts.c;
        case (dec.kind)
          K_ALNUM: begin
            cmd.emit = 1'b1;
            if (sts.emit_ok) begin
              state_next = S_FIN;
            end
          end
          K_OPEN: state_next = S_OP_PUSH;
          K_CLOSE: begin
            mode_next  = M_PAREN;
            state_next = S_RD;
          end
          K_BIN, K_REL: begin
            mode_next  = M_PRIO;
            state_next = S_RD;
          end
          default: begin
            cmd.emit = 1'b1;
            cmd.st   = ST_UNKNOWN;
            if (sts.emit_ok) begin
              state_next = S_FIN;
            end
          end
        endcase
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = sts.empty ? S_LEND : S_CHK;
      end
      S_CHK: begin
        if (stop) begin
          state_next = S_LEND;
        end else begin
          cmd.emit = 1'b1;
          cmd.ch   = op_first(sts.top);
          if (sts.emit_ok) begin
            cmd.pop    = 1'b1;
            state_next = (op_second(sts.top) != CH_NUL) ? S_POP2 : S_RD;
          end
        end
      end
      S_POP2: begin
        cmd.emit = 1'b1;
        cmd.ch   = op_second(sts.top);
        if (sts.emit_ok) begin
          state_next = S_RD;
        end
      end
      S_LEND: begin
        case (mode)
          M_PRIO: begin
            if (dec.kind == K_REL) begin
              cmd.set_pend = 1'b1;
              cmd.pend_val = dec.pend;
              state_next   = S_FIN;
            end else begin
              state_next = S_OP_PUSH;
            end
          end
          M_PAREN: begin
            if (!sts.empty) begin
              // drop the matching open paren
              cmd.pop    = 1'b1;
              state_next = S_FIN;
            end else begin
              cmd.emit = 1'b1;
              cmd.ch   = CH_RPAREN;
              cmd.st   = ST_UNMATCHED;
              if (sts.emit_ok) begin
                state_next = S_FIN;
              end
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_OP_PUSH: begin
        cmd.push = 1'b1;
        cmd.emit = sts.full;
        cmd.st   = ST_OVERFLOW;
        cmd.code = dec.code;
        cmd.ch   = sts.c;
        if (push_done) begin
          cmd.set_skip = dec.two;
          state_next   = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.fin) begin
          cmd.clr_skip = 1'b1;
          if (sts.pend != PEND_NONE) begin
            state_next = S_FIN_PUSH;
          end else begin
            mode_next  = M_ALL;
            state_next = S_RD;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_FIN_PUSH: begin
        cmd.push = 1'b1;
        cmd.emit = sts.full;
        cmd.st   = ST_OVERFLOW;
        cmd.code = (sts.pend == PEND_GT) ? OP_GT : OP_LT;
        cmd.ch   = (sts.pend == PEND_GT) ? CH_GT : CH_LT;
        if (push_done) begin
          cmd.clr_pend = 1'b1;
          mode_next    = M_ALL;
          state_next   = S_RD;
        end
      end
      S_DONE: begin
        // held result leaves marked as the last of the transaction
        cmd.flush = 1'b1;
        if (!sts.hold_valid || sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/i2p_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_checker
// Port-level checks for the infix-to-postfix converter.
// ----------------------------------------------------------------------------
module i2p_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input i2p_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_ready,
  input i2p_pkg::result_t result
);
  import i2p_pkg::*;

  logic alnum;
  assign alnum = (result.out_char >= CH_0 && result.out_char <= CH_9) ||
                 (result.out_char >= CH_UA && result.out_char <= CH_UZ) ||
                 (result.out_char >= CH_LA && result.out_char <= CH_LZ);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // one character in flight: no back-to-back transactions
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input accepted while busy");

  a_unmatched: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_UNMATCHED |-> result.out_char == CH_RPAREN)
    else $error("unmatched status on a character other than close paren");

  a_unknown: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_UNKNOWN |-> !alnum)
    else $error("letter or digit flagged as unknown");

endmodule

bind infix_to_postfix_converter_top i2p_checker u_i2p_checker (.*);
`default_nettype wire
